// ===== sv/mcs51_ipd_pkg.sv =====
// Package for the MCS-51 instruction predecoder: opcode constants, the
// operand-format length table, the instruction record type and decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package mcs51_ipd_pkg;

   // Target kinds reported with each instruction
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_RELATIVE = 2'd1;
   localparam logic [1:0] KIND_PAGED    = 2'd2;
   localparam logic [1:0] KIND_LONG     = 2'd3;

   // Opcodes and opcode patterns
   localparam logic [7:0]  OP_LJMP      = 8'h02;
   localparam logic [7:0]  OP_LCALL     = 8'h12;
   localparam logic [7:0]  OP_SJMP      = 8'h80;
   localparam logic [7:0]  OP_JMP_IND   = 8'h73;
   localparam logic [7:0]  OP_RESERVED  = 8'ha5;
   localparam logic [7:0]  OP_DJNZ_DIR  = 8'hd5;
   localparam logic [7:0]  OP_RET_MASK  = 8'hef;
   localparam logic [7:0]  OP_RET       = 8'h22;
   localparam logic [4:0]  OP_AJMP_LO   = 5'h01;
   localparam logic [4:0]  OP_ACALL_LO  = 5'h11;
   localparam logic [4:0]  OP_DJNZ_RN_HI = 5'b11011;
   localparam logic [3:0]  HI_CJNE      = 4'hb;
   localparam logic [15:0] PAGE_MASK    = 16'hf800;

   // Instruction length by operand-format group and high nibble
   localparam logic [1:0] LEN_TAB [8][16] = '{
      '{2'd1,2'd3,2'd3,2'd3,2'd2,2'd2,2'd2,2'd2,2'd2,2'd3,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1},
      '{2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2},
      '{2'd3,2'd3,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1},
      '{2'd1,2'd1,2'd1,2'd1,2'd3,2'd3,2'd3,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1},
      '{2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd1},
      '{2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd3,2'd3,2'd2,2'd1,2'd3,2'd2,2'd3,2'd2,2'd2},
      '{2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd1,2'd2,2'd3,2'd1,2'd1,2'd1,2'd1},
      '{2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd1,2'd2,2'd3,2'd1,2'd2,2'd1,2'd1}
   };

   // One assembled instruction
   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] address;
      logic [1:0]  length;
      logic [7:0]  operand0;
      logic [7:0]  operand1;
   } instr_type;

   // Total instruction length from the opcode
   function automatic logic [1:0] op_length(input logic [7:0] op);
      logic [2:0] grp;
      if (op[3:0] < 4'd6) begin
         grp = op[2:0];
      end else if (op[3:0] < 4'd8) begin
         grp = 3'd6;
      end else begin
         grp = 3'd7;
      end
      return LEN_TAB[grp][op[7:4]];
   endfunction

   // Conditional and short jumps with a relative offset
   function automatic logic is_relative(input logic [7:0] op);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = op[7:4];
      lo = op[3:0];
      return (lo == 4'd0 && hi >= 4'd1 && hi <= 4'd8) ||
             (hi == HI_CJNE && lo >= 4'd4) ||
             (op == OP_DJNZ_DIR) || (op[7:3] == OP_DJNZ_RN_HI);
   endfunction

endpackage

// ===== sv/mcs51_instruction_predecoder.sv =====
// Top level of the MCS-51 instruction predecoder.
// Depends on mcs51_ipd_pkg.
`timescale 1ns / 1ps

// Usage:
//  The req_ channel carries one code byte per item with its program address
//  and a restart mark. Bytes are collected into instructions; the length of
//  each comes from its opcode. A restart drops any partial instruction.
//  The rsp_ channel carries one item per completed instruction: address,
//  opcode, length, operands, branch target and kind, and flow flags.
//  Path: the instruction's last byte is captured in the record register,
//  then its decoded result is registered in the result register.
//  Throughput: one byte per cycle unless the output stalls; the length
//  lookup is at the input, two 16-bit adds precede the result register.
//  Stalls: when rsp_ready is low the result register holds, the record
//  register fills, and only then does req_ready drop.
//  Reset: synchronous, active high; the block expects an opcode next and
//  holds no pending results.
module mcs51_instruction_predecoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   input  logic [15:0] req_byte_address,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_instr_address,
   output logic [7:0]  rsp_opcode,
   output logic [1:0]  rsp_instr_length,
   output logic [7:0]  rsp_first_operand,
   output logic [7:0]  rsp_second_operand,
   output logic [15:0] rsp_target_address,
   output logic [1:0]  rsp_target_kind,
   output logic        rsp_is_call,
   output logic        rsp_is_break,
   output logic        rsp_is_indirect,
   output logic        rsp_is_undefined
);
   import mcs51_ipd_pkg::*;

   // Assembly state
   logic [7:0]  op_ff, op_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  opnd0_ff, opnd0_in;
   logic [7:0]  opnd1_ff, opnd1_in;
   logic [1:0]  seen_ff, seen_in;
   logic [1:0]  need_ff, need_in;

   // Completed record stage
   logic        rec_valid_ff, rec_valid_in;
   instr_type   rec_ff, rec_in;
   logic        rec_fire;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_addr_ff, out_target_ff, out_target_in;
   logic [7:0]  out_op_ff, out_a1_ff, out_a2_ff;
   logic [1:0]  out_len_ff, out_kind_ff, out_kind_in;
   logic        out_call_ff, out_break_ff, out_ind_ff, out_undef_ff;
   logic        out_call_in, out_break_in;

   logic        accept;
   logic        rec_advance;
   logic        start;
   logic [1:0]  new_len;
   logic [1:0]  seen_next;
   logic [15:0] next_addr;
   logic [7:0]  offset;

   // Handshake: a new byte may enter whenever the record slot will be free
   assign rec_advance = rec_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !rec_valid_ff || rec_advance;
   assign accept      = req_valid && req_ready;

   // Instruction assembly
   assign start     = req_restart || (seen_ff == 2'd0) || (seen_ff >= need_ff);
   assign new_len   = op_length(req_code_byte);
   assign seen_next = seen_ff + 2'd1;

   always_comb begin
      op_in    = op_ff;
      addr_in  = addr_ff;
      opnd0_in = opnd0_ff;
      opnd1_in = opnd1_ff;
      seen_in  = seen_ff;
      need_in  = need_ff;
      rec_fire = 1'b0;
      if (accept) begin
         if (start) begin
            op_in    = req_code_byte;
            addr_in  = req_byte_address;
            opnd0_in = 8'd0;
            opnd1_in = 8'd0;
            need_in  = new_len;
            if (new_len <= 2'd1) begin
               seen_in  = 2'd0;
               rec_fire = 1'b1;
            end else begin
               seen_in = 2'd1;
            end
         end else begin
            if (seen_ff == 2'd1) begin
               opnd0_in = req_code_byte;
            end else begin
               opnd1_in = req_code_byte;
            end
            if (seen_next >= need_ff) begin
               seen_in  = 2'd0;
               rec_fire = 1'b1;
            end else begin
               seen_in = seen_next;
            end
         end
      end
   end

   // Record of the completed instruction
   always_comb begin
      rec_in.opcode   = op_in;
      rec_in.address  = addr_in;
      rec_in.length   = need_in;
      rec_in.operand0 = opnd0_in;
      rec_in.operand1 = opnd1_in;
      if (rec_fire) begin
         rec_valid_in = 1'b1;
      end else if (rec_advance) begin
         rec_valid_in = 1'b0;
      end else begin
         rec_valid_in = rec_valid_ff;
      end
   end

   // Target and flag decode
   assign next_addr = rec_ff.address + {14'd0, rec_ff.length};
   assign offset    = (rec_ff.length == 2'd3) ? rec_ff.operand1 : rec_ff.operand0;

   always_comb begin
      out_kind_in   = KIND_NONE;
      out_target_in = 16'd0;
      if (rec_ff.opcode[4:0] == OP_AJMP_LO || rec_ff.opcode[4:0] == OP_ACALL_LO) begin
         out_kind_in   = KIND_PAGED;
         out_target_in = {next_addr[15:11], rec_ff.opcode[7:5], rec_ff.operand0};
      end else if (rec_ff.opcode == OP_LJMP || rec_ff.opcode == OP_LCALL) begin
         out_kind_in   = KIND_LONG;
         out_target_in = {rec_ff.operand0, rec_ff.operand1};
      end else if (is_relative(rec_ff.opcode)) begin
         out_kind_in   = KIND_RELATIVE;
         out_target_in = next_addr + {{8{offset[7]}}, offset};
      end
      out_call_in  = (rec_ff.opcode[4:0] == OP_ACALL_LO) || (rec_ff.opcode == OP_LCALL);
      out_break_in = ((rec_ff.opcode & OP_RET_MASK) == OP_RET) ||
                     (rec_ff.opcode[4:0] == OP_AJMP_LO) || (rec_ff.opcode == OP_LJMP) ||
                     (rec_ff.opcode == OP_SJMP) || (rec_ff.opcode == OP_JMP_IND);
      if (rec_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 2'd0;
         need_ff      <= 2'd1;
         rec_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         need_ff      <= need_in;
         rec_valid_ff <= rec_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      opnd0_ff <= opnd0_in;
      opnd1_ff <= opnd1_in;
      if (rec_fire) begin
         rec_ff <= rec_in;
      end
      if (rec_advance) begin
         out_addr_ff   <= rec_ff.address;
         out_op_ff     <= rec_ff.opcode;
         out_len_ff    <= rec_ff.length;
         out_a1_ff     <= rec_ff.operand0;
         out_a2_ff     <= rec_ff.operand1;
         out_target_ff <= out_target_in;
         out_kind_ff   <= out_kind_in;
         out_call_ff   <= out_call_in;
         out_break_ff  <= out_break_in;
         out_ind_ff    <= (rec_ff.opcode == OP_JMP_IND);
         out_undef_ff  <= (rec_ff.opcode == OP_RESERVED);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_instr_address  = out_addr_ff;
   assign rsp_opcode         = out_op_ff;
   assign rsp_instr_length   = out_len_ff;
   assign rsp_first_operand  = out_a1_ff;
   assign rsp_second_operand = out_a2_ff;
   assign rsp_target_address = out_target_ff;
   assign rsp_target_kind    = out_kind_ff;
   assign rsp_is_call        = out_call_ff;
   assign rsp_is_break       = out_break_ff;
   assign rsp_is_indirect    = out_ind_ff;
   assign rsp_is_undefined   = out_undef_ff;

   // Checks
   a_seen_below_need: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd0 |-> seen_ff < need_ff)
      else $error("byte count reached instruction length without completing");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_instr_length != 2'd0)
      else $error("result item with zero length");

   a_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_kind == KIND_NONE |-> rsp_target_address == 16'd0)
      else $error("target address set without a target kind");

   a_indirect_breaks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_indirect |-> rsp_is_break)
      else $error("indirect jump not marked as flow break");

   a_record_not_lost: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff && !rec_advance |=> rec_valid_ff && $stable(rec_ff))
      else $error("pending instruction record dropped or overwritten");

endmodule

// ===== tb/mcs51_ipd_checker.sv =====
// Scoreboard for the MCS-51 instruction predecoder: watches both channels,
// predicts each decoded instruction and compares it with the block's output.
// Depends on mcs51_ipd_pkg for opcode and target-kind constants.
`timescale 1ns / 1ps

module mcs51_ipd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_code_byte,
   input  logic [15:0] req_byte_address,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_instr_address,
   input  logic [7:0]  rsp_opcode,
   input  logic [1:0]  rsp_instr_length,
   input  logic [7:0]  rsp_first_operand,
   input  logic [7:0]  rsp_second_operand,
   input  logic [15:0] rsp_target_address,
   input  logic [1:0]  rsp_target_kind,
   input  logic        rsp_is_call,
   input  logic        rsp_is_break,
   input  logic        rsp_is_indirect,
   input  logic        rsp_is_undefined,
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import mcs51_ipd_pkg::*;

   // One decoded instruction as seen on the rsp_ channel
   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  opcode;
      logic [1:0]  len;
      logic [7:0]  op1;
      logic [7:0]  op2;
      logic [15:0] target;
      logic [1:0]  kind;
      logic        call;
      logic        brk;
      logic        ind;
      logic        undef;
   } decoded_instr_type;

   // Instruction length per operand-format group (rows) and high nibble
   localparam logic [1:0] FORMAT_LEN [8][16] = '{
      '{2'd1,2'd3,2'd3,2'd3,2'd2,2'd2,2'd2,2'd2,2'd2,2'd3,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1},
      '{2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2},
      '{2'd3,2'd3,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1},
      '{2'd1,2'd1,2'd1,2'd1,2'd3,2'd3,2'd3,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1},
      '{2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd1},
      '{2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd3,2'd3,2'd2,2'd1,2'd3,2'd2,2'd3,2'd2,2'd2},
      '{2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd1,2'd2,2'd3,2'd1,2'd1,2'd1,2'd1},
      '{2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd1,2'd2,2'd3,2'd1,2'd2,2'd1,2'd1}
   };

   // Assembly state of the predictor
   logic [7:0]  asm_opcode;
   logic [15:0] asm_address;
   logic [7:0]  asm_operand0;
   logic [7:0]  asm_operand1;
   logic [1:0]  asm_seen;
   logic [1:0]  asm_needed;

   decoded_instr_type expected_instrs [$];
   int mismatch_count = 0;
   int pending_r = 0;
   int checked_r = 0;

   assign fail_count = mismatch_count;
   assign pending    = pending_r;
   assign checked    = checked_r;

   function automatic logic [1:0] instr_bytes(input logic [7:0] op);
      logic [2:0] row;
      if (op[3:0] < 4'd6) begin
         row = op[2:0];
      end else if (op[3:0] < 4'd8) begin
         row = 3'd6;
      end else begin
         row = 3'd7;
      end
      return FORMAT_LEN[row][op[7:4]];
   endfunction

   // jbc/jb/jnb/jc/jnc/jz/jnz/sjmp, cjne, djnz
   function automatic logic has_rel_offset(input logic [7:0] op);
      if (op[3:0] == 4'h0 && op[7:4] >= 4'h1 && op[7:4] <= 4'h8) return 1'b1;
      if (op[7:4] == HI_CJNE && op[3:0] >= 4'h4) return 1'b1;
      if (op == OP_DJNZ_DIR || op[7:3] == OP_DJNZ_RN_HI) return 1'b1;
      return 1'b0;
   endfunction

   function automatic string show(input decoded_instr_type r);
      return $sformatf({"addr=%h op=%h len=%0d opnds=%h,%h target=%h kind=%0d ",
                        "call=%b break=%b indirect=%b undefined=%b"},
                       r.addr, r.opcode, r.len, r.op1, r.op2, r.target, r.kind,
                       r.call, r.brk, r.ind, r.undef);
   endfunction

   // Build the expected record of the instruction just completed
   task automatic complete_instr();
      decoded_instr_type r;
      logic [15:0] next_pc;
      logic [7:0]  offset;
      r        = '0;
      r.addr   = asm_address;
      r.opcode = asm_opcode;
      r.len    = asm_needed;
      r.op1    = (asm_needed >= 2'd2) ? asm_operand0 : 8'h00;
      r.op2    = (asm_needed == 2'd3) ? asm_operand1 : 8'h00;
      next_pc  = asm_address + 16'(asm_needed);
      if (asm_opcode[4:0] == OP_AJMP_LO || asm_opcode[4:0] == OP_ACALL_LO) begin
         r.kind   = KIND_PAGED;
         r.target = (next_pc & PAGE_MASK) | {5'b0, asm_opcode[7:5], r.op1};
      end else if (asm_opcode == OP_LJMP || asm_opcode == OP_LCALL) begin
         r.kind   = KIND_LONG;
         r.target = {r.op1, r.op2};
      end else if (has_rel_offset(asm_opcode)) begin
         offset   = (asm_needed == 2'd3) ? r.op2 : r.op1;
         r.kind   = KIND_RELATIVE;
         r.target = next_pc + {{8{offset[7]}}, offset};
      end else begin
         r.kind   = KIND_NONE;
      end
      r.call  = asm_opcode[4:0] == OP_ACALL_LO || asm_opcode == OP_LCALL;
      r.brk   = (asm_opcode & OP_RET_MASK) == OP_RET || asm_opcode[4:0] == OP_AJMP_LO ||
                asm_opcode == OP_LJMP || asm_opcode == OP_SJMP || asm_opcode == OP_JMP_IND;
      r.ind   = asm_opcode == OP_JMP_IND;
      r.undef = asm_opcode == OP_RESERVED;
      expected_instrs.push_back(r);
   endtask

   // Feed one accepted code byte into the predictor
   task automatic absorb_byte(input logic [7:0] b, input logic [15:0] a, input logic rs);
      if (rs || asm_seen == 2'd0 || asm_seen >= asm_needed) begin
         asm_opcode   = b;
         asm_address  = a;
         asm_operand0 = 8'h00;
         asm_operand1 = 8'h00;
         asm_needed   = instr_bytes(b);
         if (asm_needed <= 2'd1) begin
            asm_seen = 2'd0;
            complete_instr();
         end else begin
            asm_seen = 2'd1;
         end
      end else begin
         // operand byte: its address plays no part
         if (asm_seen == 2'd1) begin
            asm_operand0 = b;
         end else begin
            asm_operand1 = b;
         end
         asm_seen = asm_seen + 2'd1;
         if (asm_seen >= asm_needed) begin
            asm_seen = 2'd0;
            complete_instr();
         end
      end
   endtask

   task automatic compare_result();
      decoded_instr_type got;
      decoded_instr_type want;
      got = '{rsp_instr_address, rsp_opcode, rsp_instr_length, rsp_first_operand,
              rsp_second_operand, rsp_target_address, rsp_target_kind, rsp_is_call,
              rsp_is_break, rsp_is_indirect, rsp_is_undefined};
      checked_r++;
      if (expected_instrs.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("%t: unexpected instruction: %s", $realtime, show(got));
         end
         mismatch_count++;
      end else begin
         want = expected_instrs.pop_front();
         if (got !== want) begin
            if (mismatch_count < 10) begin
               $display("%t: instruction mismatch", $realtime);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
            mismatch_count++;
         end
      end
   endtask

   // Predict on each accepted byte, compare on each accepted result
   always @(posedge clock) begin
      if (reset) begin
         asm_opcode   = 8'h00;
         asm_address  = 16'h0000;
         asm_operand0 = 8'h00;
         asm_operand1 = 8'h00;
         asm_seen     = 2'd0;
         asm_needed   = 2'd1;
         expected_instrs.delete();
      end else begin
         if (req_valid && req_ready) begin
            absorb_byte(req_code_byte, req_byte_address, req_restart);
         end
         if (rsp_valid && rsp_ready) begin
            compare_result();
         end
      end
      pending_r <= expected_instrs.size();
   end

endmodule

// ===== tb/mcs51_instruction_predecoder_tb.sv =====
// Testbench top for the MCS-51 instruction predecoder: clock, reset, code byte
// stimulus, output-side stalls and the verdict.
// Depends on mcs51_ipd_pkg, mcs51_instruction_predecoder and mcs51_ipd_checker.
`timescale 1ns / 1ps

module mcs51_instruction_predecoder_tb;
   import mcs51_ipd_pkg::*;

   localparam int RANDOM_BYTES = 1900;
   localparam int LONG_HOLD    = 60;
   localparam int CYCLE_LIMIT  = 500000;

   localparam logic [7:0] OP_NOP         = 8'h00;
   localparam logic [7:0] OP_RETI        = 8'h32;
   localparam logic [7:0] OP_MOV_DPTR    = 8'h90;
   localparam logic [7:0] OP_MOV_DIR_DIR = 8'h85;

   // Directed items: {code byte, address, restart}
   localparam int N_DIRECTED = 26;
   localparam logic [24:0] DIRECTED [N_DIRECTED] = '{
      {OP_NOP, 16'h0000, 1'b0},                   // opcode straight after reset, no restart
      {OP_LJMP, 16'hfffd, 1'b1},                  // next address wraps to zero
      {8'hff, 16'hfffe, 1'b0},
      {8'hff, 16'hffff, 1'b0},
      {OP_LJMP, 16'h0100, 1'b0},                  // dropped by the restart below
      {OP_LCALL, 16'h0102, 1'b1},
      {8'h00, 16'h8000, 1'b0},                    // operand addresses are ignored
      {8'h00, 16'h0104, 1'b0},
      {{3'h7, OP_AJMP_LO}, 16'hfffe, 1'b0},       // paged target across the wrap
      {8'hff, 16'hffff, 1'b0},
      {OP_SJMP, 16'h0000, 1'b0},                  // backward offset below zero
      {8'h80, 16'h0001, 1'b0},
      {{HI_CJNE, 4'h4}, 16'hff00, 1'b1},          // three-byte relative
      {8'h00, 16'hff01, 1'b0},
      {8'h7f, 16'hff02, 1'b0},
      {{OP_DJNZ_RN_HI, 3'h0}, 16'h1234, 1'b0},
      {8'hfe, 16'h1235, 1'b0},
      {OP_JMP_IND, 16'h2000, 1'b0},
      {OP_RET, 16'h2001, 1'b0},
      {OP_RESERVED, 16'h2002, 1'b1},              // reserved opcode
      {OP_MOV_DPTR, 16'h2003, 1'b0},              // 16-bit immediate, not a target
      {8'h12, 16'h2004, 1'b0},
      {8'h34, 16'h2005, 1'b0},
      {OP_MOV_DIR_DIR, 16'h2006, 1'b0},           // direct-to-direct move
      {8'haa, 16'h2007, 1'b0},
      {8'h55, 16'h2008, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_code_byte = 8'h00;
   logic [15:0] req_byte_address = 16'h0000;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_instr_address;
   logic [7:0]  rsp_opcode;
   logic [1:0]  rsp_instr_length;
   logic [7:0]  rsp_first_operand;
   logic [7:0]  rsp_second_operand;
   logic [15:0] rsp_target_address;
   logic [1:0]  rsp_target_kind;
   logic        rsp_is_call;
   logic        rsp_is_break;
   logic        rsp_is_indirect;
   logic        rsp_is_undefined;

   int fail_count;
   int pending;
   int checked;

   // Sender state
   int          bytes_sent = 0;
   int          burst_left = 0;
   logic        pacing = 1'b0;
   logic        force_restart = 1'b0;
   logic [15:0] pc = 16'h0000;

   // Long output holds requested by the sender, served by the receiver
   int holds_asked = 0;
   int holds_taken = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_tick = 0;

   mcs51_instruction_predecoder DUT (.*);

   mcs51_ipd_checker scoreboard (.*);

   always #5 clock = ~clock;

   // Run limit
   initial begin
      #(CYCLE_LIMIT * 10);
      $display("timeout: %0d instructions still outstanding", pending);
      $display("** mcs51_instruction_predecoder: FAILED **");
      $finish;
   end

   // Receiver: long holds on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_taken != holds_asked) begin
         holds_taken <= holds_taken + 1;
         hold_left   <= LONG_HOLD - 1;
         rsp_ready   <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(10, 120);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 3) != 0;
            2:       rsp_ready <= rx_tick[1:0] == 2'b00;
            default: rsp_ready <= $urandom_range(0, 2) == 0;
         endcase
      end
   end

   // Offer one code byte, with a random gap between bursts when pacing, until taken
   task automatic send_byte(input logic [7:0] b, input logic [15:0] a, input logic rs);
      int gap;
      if (pacing) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid        <= 1'b1;
      req_code_byte    <= b;
      req_byte_address <= a;
      req_restart      <= rs;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Stop sending until every predicted instruction has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Opcode mix weighted toward branches and flow changes
   function automatic logic [7:0] pick_opcode();
      logic [7:0] r;
      r = 8'($urandom);
      case ($urandom_range(0, 11))
         0: r[4:0] = OP_AJMP_LO;
         1: r[4:0] = OP_ACALL_LO;
         2: r = $urandom_range(0, 1) ? OP_LJMP : OP_LCALL;
         3: r = {4'($urandom_range(1, 8)), 4'h0};
         4: r = {HI_CJNE, 2'b01, r[1:0]};
         5: r = $urandom_range(0, 1) ? OP_DJNZ_DIR : {OP_DJNZ_RN_HI, r[2:0]};
         6: begin
            case ($urandom_range(0, 3))
               0:       r = OP_JMP_IND;
               1:       r = OP_RET;
               2:       r = OP_RETI;
               default: r = OP_RESERVED;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   // One instruction; now and then a stray byte or a cut-short instruction
   task automatic send_instr();
      logic [7:0] op;
      int n;
      int k;
      logic rs;
      if ($urandom_range(0, 99) < 4) begin
         send_byte(8'($urandom), 16'($urandom), 1'($urandom));
         return;
      end
      op = pick_opcode();
      n  = op_length(op);
      k  = n;
      if (n > 1 && $urandom_range(0, 99) < 8) begin
         k = $urandom_range(1, n - 1);
      end
      if ($urandom_range(0, 99) < 6) begin
         pc = 16'($urandom);
      end else if ($urandom_range(0, 99) < 3) begin
         pc = 16'($urandom_range(16'hfff8, 16'hffff));
      end
      rs = force_restart ? 1'b1 : 1'($urandom);
      force_restart = 1'b0;
      send_byte(op, pc, rs);
      for (int i = 1; i < k; i++) begin
         send_byte(8'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom) : pc + 16'(i),
                   1'b0);
      end
      pc = pc + 16'(n);
      if (k < n) force_restart = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering back to back
   task automatic hold_phase();
      holds_asked <= holds_asked + 1;
      pacing = 1'b0;
      repeat (40) send_instr();
      pacing = 1'b1;
   endtask

   initial begin
      int instr_count;
      instr_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, long, paged, relative and indirect branches, a return, the special cases
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_byte(DIRECTED[i][24:17], DIRECTED[i][16:1], DIRECTED[i][0]);
      end
      drain_results();

      // Random part
      pacing = 1'b1;
      while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
         instr_count++;
         if (instr_count % 350 == 0) begin
            drain_results();
         end else if (instr_count % 350 == 175) begin
            hold_phase();
         end else begin
            send_instr();
         end
      end
      drain_results();
      repeat (20) @(posedge clock);

      $display("Covered %0d code bytes (directed and random, with restarts, cut-short and",
               bytes_sent);
      $display("stray bytes) and checked %0d decoded instructions across %0d long holds.",
               checked, holds_asked);
      if (fail_count == 0) begin
         $display("** mcs51_instruction_predecoder: PASSED **");
      end else begin
         $display("%0d failures", fail_count);
         $display("** mcs51_instruction_predecoder: FAILED **");
      end
      $finish;
   end

endmodule
